// ----- rtl/core/mrla_pkg.sv -----
// mrla_pkg: types, sizes, microcode program and decode helpers for the
// min request limit arbiter; no dependencies, used by every file in rtl/core
`timescale 1ns / 1ps

package mrla_pkg;

	// sizes
	localparam int POLICIES    = 8;
	localparam int LIMIT_TYPES = 4;
	localparam int VALUE_BITS  = 32;
	localparam int KINDS       = 3;

	localparam int POL_W     = (POLICIES > 1) ? $clog2(POLICIES) : 1;
	localparam int TYPE_W    = (LIMIT_TYPES > 1) ? $clog2(LIMIT_TYPES) : 1;
	localparam int KIND_W    = 2;
	localparam int ADDR_W    = KIND_W + POL_W + TYPE_W;
	localparam int MEM_DEPTH = KINDS << (POL_W + TYPE_W);

	typedef enum logic [1:0] {
		MODE_COMMIT  = 2'd0,
		MODE_PREVIEW = 2'd1,
		MODE_REMOVE  = 2'd2,
		MODE_READ    = 2'd3
	} mode_t;

	typedef enum logic {
		ST_OK      = 1'b0,
		ST_NOT_SET = 1'b1
	} status_t;

	typedef struct packed {
		mode_t       mode;
		logic [1:0]  quantity_kind;
		logic [2:0]  requester;
		logic [1:0]  limit_type;
		logic [31:0] request_value;
	} req_t;

	typedef struct packed {
		logic [31:0] result_value;
		status_t     status;
	} rsp_t;

	// datapath actions, one per control word
	typedef enum logic [3:0] {
		ACT_NOP,
		ACT_SCAN_INIT_CP,
		ACT_SCAN_RD,
		ACT_CP_WRITE,
		ACT_EMIT_BEST,
		ACT_RM_INIT,
		ACT_RM_TAKE,
		ACT_CLR_WIN,
		ACT_SCAN_INIT_RM,
		ACT_WIN_IF_FOUND,
		ACT_TYPE_INC,
		ACT_KIND_INC,
		ACT_EMIT_ZERO,
		ACT_EMIT_READ
	} act_t;

	// next-step selection
	typedef enum logic [3:0] {
		C_NEXT,
		C_GOTO,
		C_DISPATCH,
		C_SCAN_LOOP,
		C_SKIP_NOT_HAD,
		C_SKIP_NONE_HAD,
		C_JUMP_KIND_HAS,
		C_LOOP_TYPES,
		C_LOOP_KINDS,
		C_EMIT
	} cond_t;

	typedef logic [4:0] upc_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		upc_t  target;
	} ucw_t;

	// status from the datapath to the sequencer
	typedef struct packed {
		logic scan_last;
		logic had_cur;
		logic had_any;
		logic kind_has;
		logic type_last;
		logic kind_last;
	} dp_stat_t;

	// program labels
	localparam upc_t L_IDLE      = 5'd0;
	localparam upc_t L_CP_INIT   = 5'd1;
	localparam upc_t L_CP_SCAN   = 5'd2;
	localparam upc_t L_CP_DRAIN  = 5'd3;
	localparam upc_t L_CP_WRITE  = 5'd4;
	localparam upc_t L_EMIT_BEST = 5'd5;
	localparam upc_t L_RM_INIT   = 5'd6;
	localparam upc_t L_RM_KIND   = 5'd7;
	localparam upc_t L_RM_CHECK  = 5'd8;
	localparam upc_t L_RM_EMPTY  = 5'd9;
	localparam upc_t L_RM_CLRW   = 5'd10;
	localparam upc_t L_RM_TYPE   = 5'd11;
	localparam upc_t L_RM_SCAN   = 5'd12;
	localparam upc_t L_RM_DRAIN  = 5'd13;
	localparam upc_t L_RM_WIN    = 5'd14;
	localparam upc_t L_RM_TNEXT  = 5'd15;
	localparam upc_t L_RM_NKIND  = 5'd16;
	localparam upc_t L_EMIT_ZERO = 5'd17;
	localparam upc_t L_EMIT_READ = 5'd18;
	localparam upc_t L_LAST      = 5'd18;

	// control store
	function automatic ucw_t ucode_rom(input upc_t pc);
		ucw_t w;
		unique case (pc)
			L_IDLE:      w = '{ACT_NOP,          C_DISPATCH,      L_IDLE};
			L_CP_INIT:   w = '{ACT_SCAN_INIT_CP, C_NEXT,          L_IDLE};
			L_CP_SCAN:   w = '{ACT_SCAN_RD,      C_SCAN_LOOP,     L_IDLE};
			L_CP_DRAIN:  w = '{ACT_NOP,          C_NEXT,          L_IDLE};
			L_CP_WRITE:  w = '{ACT_CP_WRITE,     C_NEXT,          L_IDLE};
			L_EMIT_BEST: w = '{ACT_EMIT_BEST,    C_EMIT,          L_IDLE};
			L_RM_INIT:   w = '{ACT_RM_INIT,      C_NEXT,          L_IDLE};
			L_RM_KIND:   w = '{ACT_RM_TAKE,      C_NEXT,          L_IDLE};
			L_RM_CHECK:  w = '{ACT_NOP,          C_SKIP_NONE_HAD, L_RM_NKIND};
			L_RM_EMPTY:  w = '{ACT_NOP,          C_JUMP_KIND_HAS, L_RM_TYPE};
			L_RM_CLRW:   w = '{ACT_CLR_WIN,      C_GOTO,          L_RM_NKIND};
			L_RM_TYPE:   w = '{ACT_SCAN_INIT_RM, C_SKIP_NOT_HAD,  L_RM_TNEXT};
			L_RM_SCAN:   w = '{ACT_SCAN_RD,      C_SCAN_LOOP,     L_IDLE};
			L_RM_DRAIN:  w = '{ACT_NOP,          C_NEXT,          L_IDLE};
			L_RM_WIN:    w = '{ACT_WIN_IF_FOUND, C_NEXT,          L_IDLE};
			L_RM_TNEXT:  w = '{ACT_TYPE_INC,     C_LOOP_TYPES,    L_RM_TYPE};
			L_RM_NKIND:  w = '{ACT_KIND_INC,     C_LOOP_KINDS,    L_RM_KIND};
			L_EMIT_ZERO: w = '{ACT_EMIT_ZERO,    C_EMIT,          L_IDLE};
			L_EMIT_READ: w = '{ACT_EMIT_READ,    C_EMIT,          L_IDLE};
			default:     w = '{ACT_NOP,          C_GOTO,          L_IDLE};
		endcase
		return w;
	endfunction

	function automatic logic kind_ok(input req_t r);
		return int'(r.quantity_kind) < KINDS;
	endfunction

	function automatic logic type_ok(input req_t r);
		return int'(r.limit_type) < LIMIT_TYPES;
	endfunction

	function automatic logic who_ok(input req_t r);
		return int'(r.requester) < POLICIES;
	endfunction

	// entry point of the routine for a new beat
	function automatic upc_t dispatch(input req_t r);
		upc_t pc;
		unique case (r.mode)
			MODE_COMMIT, MODE_PREVIEW:
				pc = (kind_ok(r) && type_ok(r) && who_ok(r)) ? L_CP_INIT : L_EMIT_ZERO;
			MODE_REMOVE: pc = who_ok(r) ? L_RM_INIT : L_EMIT_ZERO;
			MODE_READ:   pc = L_EMIT_READ;
			default:     pc = L_EMIT_ZERO;
		endcase
		return pc;
	endfunction

endpackage

// ----- rtl/core/min_request_limit_arbiter_core.sv -----
// min_request_limit_arbiter_core: top level of the min request limit arbiter
// depends on mrla_pkg, mrla_sequencer, mrla_datapath
//
//  channel  signals                    beat
//  -------  -------------------------  --------------------------------------
//  req      req_valid req_ready req    mode, kind, requester, type, value
//  rsp      rsp_valid rsp_ready rsp    result_value, status
//
// one beat at a time; req_ready is high only while the sequencer sits in idle
// a read answers from the winner registers; commit/preview walk the request memory
// remove walks every kind, clearing the winners of a kind that it empties and walking
// the request memory again for each type that the requester held
// arst_n clears all present bits at once; no clearing pass is needed
// a held rsp beat stalls the sequencer at its emit step only
`timescale 1ns / 1ps

module min_request_limit_arbiter_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  mrla_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output mrla_pkg::rsp_t rsp
);

	mrla_pkg::ucw_t     ctl;
	mrla_pkg::dp_stat_t stat;
	mrla_pkg::rsp_t     rsp_next;
	mrla_pkg::upc_t     entry;
	logic               idle;
	logic               accept;
	logic               slot_free;
	logic               emit;
	logic               load;

	// output register
	logic               rsp_valid_q;
	mrla_pkg::rsp_t     rsp_q;

	assign req_ready = idle;
	assign accept    = req_valid && req_ready;
	assign entry     = mrla_pkg::dispatch(req);

	// result slot can take a new beat when empty or being drained this cycle
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign emit      = ctl.act inside {mrla_pkg::ACT_EMIT_BEST, mrla_pkg::ACT_EMIT_ZERO,
	                                   mrla_pkg::ACT_EMIT_READ};
	assign load      = emit && slot_free;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// microcode step counter and jumps
	mrla_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.entry     (entry),
		.slot_free (slot_free),
		.stat      (stat),
		.ctl       (ctl),
		.idle      (idle)
	);

	// stores and min scan
	mrla_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req      (req),
		.ctl      (ctl),
		.stat     (stat),
		.rsp_next (rsp_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= rsp_next;
		end
	end

endmodule

// ----- rtl/core/mrla_sequencer.sv -----
// mrla_sequencer: step counter and jump logic over the control store
// depends on mrla_pkg (control word, labels, datapath status)
`timescale 1ns / 1ps

module mrla_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  mrla_pkg::upc_t      entry,
	input  logic                slot_free,
	input  mrla_pkg::dp_stat_t  stat,
	output mrla_pkg::ucw_t      ctl,
	output logic                idle
);

	mrla_pkg::upc_t upc_q;
	mrla_pkg::upc_t upc_next;
	mrla_pkg::upc_t upc_inc;

	assign ctl     = mrla_pkg::ucode_rom(upc_q);
	assign idle    = (upc_q == mrla_pkg::L_IDLE);
	assign upc_inc = mrla_pkg::upc_t'(upc_q + 1'b1);

	always_comb begin
		unique case (ctl.cond)
			mrla_pkg::C_NEXT:          upc_next = upc_inc;
			mrla_pkg::C_GOTO:          upc_next = ctl.target;
			mrla_pkg::C_DISPATCH:      upc_next = accept ? entry : upc_q;
			mrla_pkg::C_SCAN_LOOP:     upc_next = stat.scan_last ? upc_inc : upc_q;
			mrla_pkg::C_SKIP_NOT_HAD:  upc_next = stat.had_cur ? upc_inc : ctl.target;
			mrla_pkg::C_SKIP_NONE_HAD: upc_next = stat.had_any ? upc_inc : ctl.target;
			mrla_pkg::C_JUMP_KIND_HAS: upc_next = stat.kind_has ? ctl.target : upc_inc;
			mrla_pkg::C_LOOP_TYPES:    upc_next = stat.type_last ? upc_inc : ctl.target;
			mrla_pkg::C_LOOP_KINDS:    upc_next = stat.kind_last ? upc_inc : ctl.target;
			mrla_pkg::C_EMIT:          upc_next = slot_free ? ctl.target : upc_q;
			default:                   upc_next = mrla_pkg::L_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= mrla_pkg::L_IDLE;
		end else begin
			upc_q <= upc_next;
		end
	end

	// step counter never leaves the program
	a_upc_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q <= mrla_pkg::L_LAST)
		else $error("step counter outside program");

endmodule

// ----- rtl/core/mrla_datapath.sv -----
// mrla_datapath: request memory, present bits, winner registers and the
// running-minimum scan unit; depends on mrla_pkg
`timescale 1ns / 1ps

module mrla_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  mrla_pkg::req_t     req,
	input  mrla_pkg::ucw_t     ctl,
	output mrla_pkg::dp_stat_t stat,
	output mrla_pkg::rsp_t     rsp_next
);

	localparam int PW = mrla_pkg::POL_W;
	localparam int TW = mrla_pkg::TYPE_W;
	localparam int KW = mrla_pkg::KIND_W;
	localparam int VW = mrla_pkg::VALUE_BITS;
	localparam int AW = mrla_pkg::ADDR_W;
	localparam int NP = mrla_pkg::POLICIES;
	localparam int NT = mrla_pkg::LIMIT_TYPES;
	localparam int NK = mrla_pkg::KINDS;

	// captured beat
	mrla_pkg::mode_t mode_q;
	logic [KW-1:0]   kind_q;
	logic [PW-1:0]   who_q;
	logic [TW-1:0]   type_q;
	logic [VW-1:0]   val_q;
	logic            rd_ok_q;

	// scan unit
	logic [PW-1:0]   pol_q;
	logic [KW-1:0]   skind_q;
	logic [TW-1:0]   stype_q;
	logic            cand_q;
	logic            acc_vld_s1;
	logic            acc_cand_s1;
	logic [VW-1:0]   best_q;
	logic            found_q;
	logic [VW-1:0]   acc_val;
	logic            acc_take;

	// remove walk
	logic [KW-1:0]   kc_q;
	logic [TW-1:0]   tcur_q;
	logic [NT-1:0]   had_q;

	// stores
	logic [VW-1:0]   mem [mrla_pkg::MEM_DEPTH];
	logic [VW-1:0]   rd_q;
	logic [AW-1:0]   raddr;
	logic [AW-1:0]   waddr;
	logic [NK-1:0][NP-1:0][NT-1:0] present_q;
	logic [VW-1:0]   win_q [NK][NT];
	logic [NK-1:0][NT-1:0] win_present_q;

	logic            commit_wr;
	logic            scan_hit_who;

	assign raddr        = {skind_q, pol_q, stype_q};
	assign waddr        = {kind_q, who_q, type_q};
	assign commit_wr    = (ctl.act == mrla_pkg::ACT_CP_WRITE) &&
	                      (mode_q == mrla_pkg::MODE_COMMIT);
	assign scan_hit_who = cand_q && (pol_q == who_q);
	assign acc_val      = acc_cand_s1 ? val_q : rd_q;
	assign acc_take     = acc_vld_s1 && (!found_q || (acc_val < best_q));

	assign stat.scan_last = (pol_q == PW'(NP - 1));
	assign stat.had_cur   = had_q[tcur_q];
	assign stat.had_any   = |had_q;
	assign stat.kind_has  = |present_q[kc_q];
	assign stat.type_last = (tcur_q == TW'(NT - 1));
	assign stat.kind_last = (kc_q == KW'(NK - 1));

	always_comb begin
		unique case (ctl.act)
			mrla_pkg::ACT_EMIT_BEST: begin
				rsp_next.result_value = 32'(best_q);
				rsp_next.status       = mrla_pkg::ST_OK;
			end
			mrla_pkg::ACT_EMIT_READ: begin
				if (rd_ok_q && win_present_q[kind_q][type_q]) begin
					rsp_next.result_value = 32'(win_q[kind_q][type_q]);
					rsp_next.status       = mrla_pkg::ST_OK;
				end else begin
					rsp_next.result_value = '0;
					rsp_next.status       = mrla_pkg::ST_NOT_SET;
				end
			end
			default: begin
				rsp_next.result_value = '0;
				rsp_next.status       = mrla_pkg::ST_OK;
			end
		endcase
	end

	// beat capture
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= req.mode;
			kind_q  <= req.quantity_kind;
			who_q   <= PW'(req.requester);
			type_q  <= TW'(req.limit_type);
			val_q   <= VW'(req.request_value);
			rd_ok_q <= mrla_pkg::kind_ok(req) && mrla_pkg::type_ok(req);
		end
	end

	// request memory, read data registered
	always_ff @(posedge clk) begin
		if (commit_wr) begin
			mem[waddr] <= val_q;
		end
		rd_q <= mem[raddr];
	end

	// scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pol_q      <= '0;
			acc_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			acc_vld_s1 <= (ctl.act == mrla_pkg::ACT_SCAN_RD) &&
			              (present_q[skind_q][pol_q][stype_q] || scan_hit_who);
			if (ctl.act == mrla_pkg::ACT_SCAN_INIT_CP ||
			    ctl.act == mrla_pkg::ACT_SCAN_INIT_RM) begin
				pol_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (ctl.act == mrla_pkg::ACT_SCAN_RD) begin
					pol_q <= PW'(pol_q + 1'b1);
				end
				if (acc_take) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.act == mrla_pkg::ACT_SCAN_INIT_CP) begin
			skind_q <= kind_q;
			stype_q <= type_q;
			cand_q  <= 1'b1;
		end else if (ctl.act == mrla_pkg::ACT_SCAN_INIT_RM) begin
			skind_q <= kc_q;
			stype_q <= tcur_q;
			cand_q  <= 1'b0;
		end
		acc_cand_s1 <= scan_hit_who;
		if (acc_take) begin
			best_q <= acc_val;
		end
	end

	// remove walk counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kc_q   <= '0;
			tcur_q <= '0;
			had_q  <= '0;
		end else begin
			unique case (ctl.act)
				mrla_pkg::ACT_RM_INIT:  kc_q <= '0;
				mrla_pkg::ACT_RM_TAKE: begin
					had_q  <= present_q[kc_q][who_q];
					tcur_q <= '0;
				end
				mrla_pkg::ACT_TYPE_INC: tcur_q <= TW'(tcur_q + 1'b1);
				mrla_pkg::ACT_KIND_INC: kc_q   <= KW'(kc_q + 1'b1);
				default: ;
			endcase
		end
	end

	// present bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q     <= '0;
			win_present_q <= '0;
		end else begin
			unique case (ctl.act)
				mrla_pkg::ACT_CP_WRITE: begin
					if (mode_q == mrla_pkg::MODE_COMMIT) begin
						present_q[kind_q][who_q][type_q] <= 1'b1;
						win_present_q[kind_q][type_q]    <= 1'b1;
					end
				end
				mrla_pkg::ACT_RM_TAKE: present_q[kc_q][who_q] <= '0;
				mrla_pkg::ACT_CLR_WIN: win_present_q[kc_q]    <= '0;
				mrla_pkg::ACT_WIN_IF_FOUND: begin
					if (found_q) begin
						win_present_q[skind_q][stype_q] <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// winner values
	always_ff @(posedge clk) begin
		if (commit_wr) begin
			win_q[kind_q][type_q] <= best_q;
		end else if (ctl.act == mrla_pkg::ACT_WIN_IF_FOUND && found_q) begin
			win_q[skind_q][stype_q] <= best_q;
		end
	end

	// accumulate slot only follows a memory read step
	a_acc_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		acc_vld_s1 |-> $past(ctl.act == mrla_pkg::ACT_SCAN_RD))
		else $error("scan accumulate without read");

	// commit and preview scans always see the candidate
	a_cp_found: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.act == mrla_pkg::ACT_CP_WRITE) |-> found_q)
		else $error("commit/preview minimum missing");

	// removal leaves nothing of the requester in the walked kind
	a_rm_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.act == mrla_pkg::ACT_RM_TAKE) |=> (present_q[kc_q][who_q] == '0))
		else $error("requester entries not cleared");

endmodule

// ----- bench/tb.sv -----
// tb: self-checking bench for min_request_limit_arbiter_core, a directed table
// then three paced random phases; depends on mrla_pkg and the rtl/core files
`timescale 1ns / 1ps

module tb;

	// quantity kind codes as seen on the request beat
	localparam logic [1:0] KIND_POWER  = 2'd0;
	localparam logic [1:0] KIND_WINDOW = 2'd1;
	localparam logic [1:0] KIND_DUTY   = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam int QUIET_LIMIT  = 4000; // cycles with no handshake before giving up
	localparam int DRAIN_CYCLES = 200;  // idle clocks after the final drain, before the summary
	localparam int PHASE_BEATS  = 159;  // random beats per phase, after the remove sweep

	typedef struct {
		mrla_pkg::req_t beat;
		bit             typed;
		mrla_pkg::rsp_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	mrla_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	mrla_pkg::rsp_t rsp;

	// pacing, in percent of cycles spent idle on each side
	int send_idle = 31;
	int recv_idle = 65;

	// typed expectation of the beat now on the request channel, if any
	bit             row_typed = 1'b0;
	mrla_pkg::rsp_t row_want = '0;

	mrla_pkg::rsp_t due_rsp[$];
	row_t plan[$];

	int errors = 0;
	int beats = 0;
	int checked = 0;
	int not_set_seen = 0;
	int mode_count[4] = '{0, 0, 0, 0};
	int quiet = 0;

	// shadow of the arbiter state
	logic [31:0] ask_val [mrla_pkg::KINDS][mrla_pkg::POLICIES][mrla_pkg::LIMIT_TYPES];
	bit          ask_has [mrla_pkg::KINDS][mrla_pkg::POLICIES][mrla_pkg::LIMIT_TYPES];
	logic [31:0] win_val [mrla_pkg::KINDS][mrla_pkg::LIMIT_TYPES];
	bit          win_has [mrla_pkg::KINDS][mrla_pkg::LIMIT_TYPES];

	min_request_limit_arbiter_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #4 clk = ~clk;

	// smallest held request of one kind and type, optionally with one
	// requester's entry swapped for a candidate; returns 0 when nothing is held
	function automatic bit min_of(input int k, input int t, input bit swap, input int who,
			input logic [31:0] cand, output logic [31:0] m);
		bit found;
		logic [31:0] v;
		found = 1'b0;
		m = '0;
		for (int p = 0; p < mrla_pkg::POLICIES; p++) begin
			if (swap && p == who) begin
				v = cand;
			end else if (ask_has[k][p][t]) begin
				v = ask_val[k][p][t];
			end else begin
				continue;
			end
			if (!found || v < m) begin
				m = v;
				found = 1'b1;
			end
		end
		return found;
	endfunction

	// drop a requester from every kind and re-arbitrate what it held
	function automatic void drop_requester(input int who);
		bit had [mrla_pkg::LIMIT_TYPES];
		bit held_any;
		bit others_left;
		logic [31:0] m;
		for (int k = 0; k < mrla_pkg::KINDS; k++) begin
			held_any = 1'b0;
			others_left = 1'b0;
			for (int t = 0; t < mrla_pkg::LIMIT_TYPES; t++) begin
				had[t] = ask_has[k][who][t];
				held_any |= had[t];
				ask_has[k][who][t] = 1'b0;
			end
			if (!held_any)
				continue;
			for (int p = 0; p < mrla_pkg::POLICIES; p++)
				for (int t = 0; t < mrla_pkg::LIMIT_TYPES; t++)
					others_left |= ask_has[k][p][t];
			for (int t = 0; t < mrla_pkg::LIMIT_TYPES; t++) begin
				// an emptied type keeps its stale winner while the kind has others
				if (!others_left) begin
					win_has[k][t] = 1'b0;
				end else if (had[t] && min_of(k, t, 1'b0, 0, '0, m)) begin
					win_val[k][t] = m;
					win_has[k][t] = 1'b1;
				end
			end
		end
	endfunction

	// expected response of one accepted beat; updates the shadow state
	function automatic mrla_pkg::rsp_t arbitrate(input mrla_pkg::req_t r);
		mrla_pkg::rsp_t o;
		int k;
		int who;
		int t;
		bit in_range;
		logic [31:0] m;
		k = int'(r.quantity_kind);
		who = int'(r.requester);
		t = int'(r.limit_type);
		in_range = (k < mrla_pkg::KINDS) && (who < mrla_pkg::POLICIES) &&
			(t < mrla_pkg::LIMIT_TYPES);
		o.result_value = '0;
		o.status = mrla_pkg::ST_OK;
		case (r.mode)
			mrla_pkg::MODE_COMMIT: begin
				if (in_range) begin
					ask_val[k][who][t] = r.request_value;
					ask_has[k][who][t] = 1'b1;
					void'(min_of(k, t, 1'b0, 0, '0, m));
					win_val[k][t] = m;
					win_has[k][t] = 1'b1;
					o.result_value = m;
				end
			end
			mrla_pkg::MODE_PREVIEW: begin
				if (in_range) begin
					void'(min_of(k, t, 1'b1, who, r.request_value, m));
					o.result_value = m;
				end
			end
			mrla_pkg::MODE_REMOVE: begin
				if (who < mrla_pkg::POLICIES)
					drop_requester(who);
			end
			default: begin
				if (k < mrla_pkg::KINDS && t < mrla_pkg::LIMIT_TYPES && win_has[k][t])
					o.result_value = win_val[k][t];
				else
					o.status = mrla_pkg::ST_NOT_SET;
			end
		endcase
		return o;
	endfunction

	function automatic row_t row(input mrla_pkg::mode_t m, input logic [1:0] k,
			input int who, input int lt, input logic [31:0] v, input bit typed = 1'b0,
			input logic [31:0] want_val = '0,
			input mrla_pkg::status_t want_st = mrla_pkg::ST_OK);
		row_t x;
		x.beat.mode = m;
		x.beat.quantity_kind = k;
		x.beat.requester = 3'(who);
		x.beat.limit_type = 2'(lt);
		x.beat.request_value = v;
		x.typed = typed;
		x.want.result_value = want_val;
		x.want.status = want_st;
		return x;
	endfunction

	// append one row to the directed table
	function automatic void add_row(input row_t x);
		plan = {plan, x};
	endfunction

	// mostly commits and reads on the real kinds, values bunched low so that
	// winners move often, with the odd unused kind and full-range value
	function automatic mrla_pkg::req_t random_beat();
		mrla_pkg::req_t r;
		int pick;
		r = '0;
		pick = $urandom_range(99);
		if (pick < 40)
			r.mode = mrla_pkg::MODE_COMMIT;
		else if (pick < 60)
			r.mode = mrla_pkg::MODE_PREVIEW;
		else if (pick < 70)
			r.mode = mrla_pkg::MODE_REMOVE;
		else
			r.mode = mrla_pkg::MODE_READ;
		r.quantity_kind = ($urandom_range(15) == 0) ? KIND_UNUSED : 2'($urandom_range(2));
		r.requester = 3'($urandom_range(7));
		r.limit_type = 2'($urandom_range(3));
		case ($urandom_range(9))
			0:          r.request_value = '0;
			1:          r.request_value = '1;
			2, 3, 4, 5: r.request_value = 32'($urandom_range(63));
			default:    r.request_value = $urandom;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h",
			$time, what, got, want);
	endtask

	// one request beat: random gap, then hold valid until the handshake
	task automatic send_beat(input mrla_pkg::req_t r, input bit typed,
			input mrla_pkg::rsp_t want);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		row_typed <= typed;
		row_want <= want;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
	endtask

	// sender holds off until every outstanding response is back
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (due_rsp.size() != 0)
			@(posedge clk);
	endtask

	// receiver pacing
	always @(posedge clk)
		rsp_ready <= ($urandom_range(99) >= recv_idle);

	// predict on every accepted request beat, check every accepted response beat
	always @(posedge clk) begin
		mrla_pkg::rsp_t want;
		if (arst_n && req_valid && req_ready) begin
			want = arbitrate(req);
			if (row_typed)
				want = row_want;
			due_rsp = {due_rsp, want};
			beats++;
			mode_count[req.mode]++;
		end
		if (arst_n && rsp_valid && rsp_ready) begin
			if (due_rsp.size() == 0) begin
				report_mismatch("unexpected response beat", rsp.result_value, '0);
			end else begin
				want = due_rsp.pop_front();
				checked++;
				if (rsp.status == mrla_pkg::ST_NOT_SET)
					not_set_seen++;
				if (rsp.result_value !== want.result_value)
					report_mismatch("result_value", rsp.result_value, want.result_value);
				if (rsp.status !== want.status)
					report_mismatch("status", 32'(rsp.status), 32'(want.status));
			end
		end
	end

	// watchdog: no handshake on either channel for too long
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet <= 0;
		else if (arst_n)
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("[%0t] no handshake for %0d cycles, %0d responses outstanding",
				$time, quiet, due_rsp.size());
			$display("min_request_limit_arbiter_core test failed");
			$finish;
		end
	end

	initial begin
		mrla_pkg::rsp_t none;
		none = '0;

		// directed table; typed expectations only where obvious
		// read of a winner never set, and of the unused kind
		add_row(row(mrla_pkg::MODE_READ, KIND_POWER, 0, 0, '0, 1'b1, '0,
			mrla_pkg::ST_NOT_SET));
		add_row(row(mrla_pkg::MODE_READ, KIND_UNUSED, 0, 0, '0, 1'b1, '0,
			mrla_pkg::ST_NOT_SET));
		// value extremes: all ones first, then zero wins
		add_row(row(mrla_pkg::MODE_COMMIT, KIND_POWER, 0, 0, 32'hFFFF_FFFF,
			1'b1, 32'hFFFF_FFFF, mrla_pkg::ST_OK));
		add_row(row(mrla_pkg::MODE_COMMIT, KIND_POWER, 1, 0, '0, 1'b1, '0, mrla_pkg::ST_OK));
		// preview replaces the requester's own entry, and adds a new one
		add_row(row(mrla_pkg::MODE_PREVIEW, KIND_POWER, 1, 0, 32'd5));
		add_row(row(mrla_pkg::MODE_PREVIEW, KIND_POWER, 6, 0, 32'hFFFF_FFFF));
		// unused kind is ignored by commit and preview
		add_row(row(mrla_pkg::MODE_COMMIT, KIND_UNUSED, 2, 1, 32'd77, 1'b1, '0,
			mrla_pkg::ST_OK));
		add_row(row(mrla_pkg::MODE_PREVIEW, KIND_UNUSED, 2, 1, 32'd77, 1'b1, '0,
			mrla_pkg::ST_OK));
		add_row(row(mrla_pkg::MODE_READ, KIND_POWER, 0, 0, '0));
		add_row(row(mrla_pkg::MODE_COMMIT, KIND_WINDOW, 2, 3, 32'd100));
		add_row(row(mrla_pkg::MODE_COMMIT, KIND_WINDOW, 3, 3, 32'd50));
		add_row(row(mrla_pkg::MODE_COMMIT, KIND_DUTY, 7, 1, 32'd7));
		// remove with others left re-arbitrates the types held
		add_row(row(mrla_pkg::MODE_REMOVE, KIND_POWER, 1, 0, '0, 1'b1, '0, mrla_pkg::ST_OK));
		add_row(row(mrla_pkg::MODE_READ, KIND_POWER, 0, 0, '0));
		add_row(row(mrla_pkg::MODE_REMOVE, KIND_DUTY, 3, 2, 32'hA5A5_A5A5, 1'b1, '0,
			mrla_pkg::ST_OK));
		add_row(row(mrla_pkg::MODE_READ, KIND_WINDOW, 0, 3, '0));
		// emptied type with others still in the kind keeps its stale winner
		add_row(row(mrla_pkg::MODE_COMMIT, KIND_WINDOW, 3, 2, 32'd9));
		add_row(row(mrla_pkg::MODE_REMOVE, KIND_WINDOW, 2, 3, '0, 1'b1, '0, mrla_pkg::ST_OK));
		add_row(row(mrla_pkg::MODE_READ, KIND_WINDOW, 5, 3, '0));
		// remove of an idle requester
		add_row(row(mrla_pkg::MODE_REMOVE, KIND_POWER, 5, 0, '0, 1'b1, '0, mrla_pkg::ST_OK));
		// last requester of a kind leaves: all its winners clear
		add_row(row(mrla_pkg::MODE_REMOVE, KIND_POWER, 7, 0, '0, 1'b1, '0, mrla_pkg::ST_OK));
		add_row(row(mrla_pkg::MODE_READ, KIND_DUTY, 0, 1, '0));
		add_row(row(mrla_pkg::MODE_PREVIEW, KIND_DUTY, 4, 0, 32'd1));
		add_row(row(mrla_pkg::MODE_READ, KIND_POWER, 0, 3, '0));
		add_row(row(mrla_pkg::MODE_COMMIT, KIND_POWER, 0, 0, 32'h8000_0000));

		// reset once, released on a clock edge
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_beat(plan[i].beat, plan[i].typed, plan[i].want);

		// three pacing phases: slow receiver, slow sender, then full rate
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 31 : (ph == 1) ? 65 : 0;
			recv_idle = (ph == 0) ? 65 : (ph == 1) ? 31 : 0;
			// sweep every requester out so that kinds empty and refill
			for (int who = 0; who < mrla_pkg::POLICIES; who++)
				send_beat(row(mrla_pkg::MODE_REMOVE, 2'($urandom_range(3)), who,
					$urandom_range(3), $urandom).beat, 1'b0, none);
			for (int i = 0; i < PHASE_BEATS; i++) begin
				if (ph == 0 && i == PHASE_BEATS / 2)
					wait_drained();
				send_beat(random_beat(), 1'b0, none);
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d beats: %0d commit, %0d preview, %0d remove, %0d read",
			beats, mode_count[mrla_pkg::MODE_COMMIT], mode_count[mrla_pkg::MODE_PREVIEW],
			mode_count[mrla_pkg::MODE_REMOVE], mode_count[mrla_pkg::MODE_READ]);
		$display("%0d responses checked (%0d not set) under three pacing mixes, %0d errors",
			checked, not_set_seen, errors);
		if (errors == 0 && due_rsp.size() == 0) begin
			$display("min_request_limit_arbiter_core test passed");
		end else begin
			if (due_rsp.size() != 0)
				$display("%0d responses never arrived", due_rsp.size());
			$display("min_request_limit_arbiter_core test failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/mrla_pkg.sv
rtl/core/mrla_sequencer.sv
rtl/core/mrla_datapath.sv
rtl/core/min_request_limit_arbiter_core.sv
bench/tb.sv
